>>> hdl/mm3h_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3h_pkg
// Shared types, constants and helper functions of the byte stream hash.
// ----------------------------------------------------------------------------
package mm3h_pkg;

    localparam logic [31:0] SEED_RESET = 32'h9747_b28c;
    localparam logic [31:0] SCR_MUL_A  = 32'hcc9e_2d51;
    localparam logic [31:0] SCR_MUL_B  = 32'h1b87_3593;
    localparam logic [31:0] MIX_ADD    = 32'he654_6b64;
    localparam logic [31:0] FIN_MUL_A  = 32'h85eb_ca6b;
    localparam logic [31:0] FIN_MUL_B  = 32'hc2b2_ae35;

    typedef enum logic [2:0] {
        MUL_SCR_A,
        MUL_TAIL_A,
        MUL_SCR_B,
        MUL_FIN_A,
        MUL_FIN_B
    } mul_op_t;

    typedef struct packed {
        logic    load;
        logic    mul_en;
        mul_op_t mul_op;
        logic    mix;
        logic    rearm;
        logic    put;
    } dp_cmd_t;

    typedef struct packed {
        logic phase_full;
        logic out_free;
    } dp_status_t;

    function automatic logic [31:0] rotl15(input logic [31:0] v);
        return {v[16:0], v[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] v);
        return {v[18:0], v[31:19]};
    endfunction

endpackage

>>> hdl/murmur3_byte_stream_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur3_byte_stream_hash
// 32-bit MurmurHash3 (x86 variant) over a key streamed one byte per word.
//
// Channel   Direction  Handshake              Contents
// key       in         key_valid / key_stall  key_byte, byte_valid, end_of_key
// hash      out        hash_valid / hash_stall hash_value
// cfg       in         cfg_valid / cfg_ready  seed
//
// The first three bytes of each group of four are packed into a register; the
// fourth takes two passes through the shared multiplier and a mix. The end of
// a key adds tail scramble and avalanche, which use the same multiplier four
// times, then the result is loaded into the output register.
// Reset loads the default seed; a held output word only delays the next hash.
// ----------------------------------------------------------------------------
module murmur3_byte_stream_hash
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_valid,
    output logic        key_stall,
    input  logic [7:0]  key_byte,
    input  logic        byte_valid,
    input  logic        end_of_key,
    output logic        hash_valid,
    input  logic        hash_stall,
    output logic [31:0] hash_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] seed
);
    import mm3h_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    mm3h_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_valid  (key_valid),
        .key_stall  (key_stall),
        .byte_valid (byte_valid),
        .end_of_key (end_of_key),
        .status     (status),
        .cmd        (cmd)
    );

    mm3h_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .key_byte   (key_byte),
        .byte_valid (byte_valid),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .seed       (seed),
        .hash_valid (hash_valid),
        .hash_stall (hash_stall),
        .hash_value (hash_value)
    );

endmodule

>>> hdl/mm3h_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3h_ctrl
// Sequencer that steps the shared multiplier through word scramble, mix,
// tail scramble, final avalanche and result hand-off.
// ----------------------------------------------------------------------------
module mm3h_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 key_valid,
    output logic                 key_stall,
    input  logic                 byte_valid,
    input  logic                 end_of_key,
    input  mm3h_pkg::dp_status_t status,
    output mm3h_pkg::dp_cmd_t    cmd
);
    import mm3h_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCR_A  = 4'd1;
    localparam logic [3:0] S_SCR_B  = 4'd2;
    localparam logic [3:0] S_MIX    = 4'd3;
    localparam logic [3:0] S_TAIL_A = 4'd4;
    localparam logic [3:0] S_TAIL_B = 4'd5;
    localparam logic [3:0] S_FIN_A  = 4'd6;
    localparam logic [3:0] S_FIN_B  = 4'd7;
    localparam logic [3:0] S_PUT    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       end_reg;
    logic       end_next;
    logic       accept;

    assign key_stall = (state_reg != S_IDLE);
    assign accept    = key_valid && !key_stall;

    always_comb
    begin
        state_next  = state_reg;
        end_next    = end_reg;
        cmd         = '0;
        cmd.mul_op  = MUL_SCR_A;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    end_next = end_of_key;
                    if (byte_valid && status.phase_full)
                    begin
                        state_next = S_SCR_A;
                    end
                    else if (end_of_key)
                    begin
                        state_next = S_TAIL_A;
                    end
                end
            end
            S_SCR_A:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_SCR_A;
                state_next = S_SCR_B;
            end
            S_SCR_B:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_SCR_B;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = end_reg ? S_TAIL_A : S_IDLE;
            end
            S_TAIL_A:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_TAIL_A;
                state_next = S_TAIL_B;
            end
            S_TAIL_B:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_SCR_B;
                state_next = S_FIN_A;
            end
            S_FIN_A:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_FIN_A;
                state_next = S_FIN_B;
            end
            S_FIN_B:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_FIN_B;
                cmd.rearm  = 1'b1;
                state_next = S_PUT;
            end
            S_PUT:
            begin
                if (status.out_free)
                begin
                    cmd.put    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            end_reg   <= end_next;
        end
    end

endmodule

>>> hdl/mm3h_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3h_dp
// Hash datapath: byte packing, one shared 32x32 multiplier, mix step,
// seed register and the output word register.
// ----------------------------------------------------------------------------
module mm3h_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mm3h_pkg::dp_cmd_t    cmd,
    output mm3h_pkg::dp_status_t status,
    input  logic [7:0]           key_byte,
    input  logic                 byte_valid,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [31:0]          seed,
    output logic                 hash_valid,
    input  logic                 hash_stall,
    output logic [31:0]          hash_value
);
    import mm3h_pkg::*;

    logic [31:0] seed_reg;
    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic [23:0] pending_reg;
    logic [23:0] pending_next;
    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [31:0] len_reg;
    logic [31:0] len_next;
    logic        open_reg;
    logic        open_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_value_reg;
    logic [31:0] out_value_next;

    logic [31:0] mul_x;
    logic [31:0] mul_k;
    logic [31:0] product;
    logic [31:0] fin_pre;
    logic [31:0] mix_rot;
    logic        cfg_write;

    assign cfg_write = cfg_valid && cfg_ready;

    assign status.phase_full = (phase_reg == 2'd3);
    assign status.out_free   = !out_valid_reg || !hash_stall;

    assign fin_pre = hash_reg ^ acc_reg ^ len_reg;
    assign mix_rot = rotl13(hash_reg ^ acc_reg);

    always_comb
    begin
        mul_x = acc_reg;
        mul_k = SCR_MUL_A;
        case (cmd.mul_op)
            MUL_SCR_A:
            begin
                mul_x = acc_reg;
                mul_k = SCR_MUL_A;
            end
            MUL_TAIL_A:
            begin
                mul_x = {8'd0, pending_reg};
                mul_k = SCR_MUL_A;
            end
            MUL_SCR_B:
            begin
                mul_x = rotl15(acc_reg);
                mul_k = SCR_MUL_B;
            end
            MUL_FIN_A:
            begin
                mul_x = fin_pre ^ {16'd0, fin_pre[31:16]};
                mul_k = FIN_MUL_A;
            end
            MUL_FIN_B:
            begin
                mul_x = acc_reg ^ {13'd0, acc_reg[31:13]};
                mul_k = FIN_MUL_B;
            end
            default:
            begin
                mul_x = acc_reg;
                mul_k = SCR_MUL_A;
            end
        endcase
    end

    assign product = mul_x * mul_k;

    always_comb
    begin
        hash_next      = hash_reg;
        pending_next   = pending_reg;
        phase_next     = phase_reg;
        len_next       = len_reg;
        open_next      = open_reg;
        acc_next       = acc_reg;
        out_value_next = out_value_reg;
        out_valid_next = out_valid_reg && hash_stall;

        if (cmd.load && byte_valid)
        begin
            open_next = 1'b1;
            len_next  = len_reg + 32'd1;
            if (phase_reg != 2'd3)
            begin
                pending_next[{phase_reg, 3'b000} +: 8] = key_byte;
                phase_next = phase_reg + 2'd1;
            end
            else
            begin
                acc_next     = {key_byte, pending_reg};
                pending_next = '0;
                phase_next   = '0;
            end
        end

        if (cmd.mul_en)
        begin
            acc_next = product;
        end

        if (cmd.mix)
        begin
            hash_next = mix_rot + {mix_rot[29:0], 2'b00} + MIX_ADD;
        end

        if (cmd.rearm)
        begin
            hash_next    = seed_reg;
            pending_next = '0;
            phase_next   = '0;
            len_next     = '0;
            open_next    = 1'b0;
        end

        if (cfg_write && !open_reg)
        begin
            hash_next = seed;
        end

        if (cmd.put)
        begin
            out_value_next = acc_reg ^ {16'd0, acc_reg[31:16]};
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= SEED_RESET;
            hash_reg      <= SEED_RESET;
            pending_reg   <= '0;
            phase_reg     <= '0;
            len_reg       <= '0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                seed_reg <= seed;
            end
            hash_reg      <= hash_next;
            pending_reg   <= pending_next;
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        out_value_reg <= out_value_next;
    end

    assign hash_valid = out_valid_reg;
    assign hash_value = out_value_reg;

endmodule
